// ===== design/fst_pkg.sv =====
// shared types and constants for the flow statistics table
package fst_pkg;

  // table geometry
  localparam int FLOW_SLOTS = 256;
  localparam int KEY_BITS   = 104;
  localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  // the key fields carry 104 bits, so a wider key setting adds nothing
  localparam int KEY_W      = (KEY_BITS < 104) ? KEY_BITS : 104;

  // result status codes
  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  // input beat
  typedef struct packed {
    logic [63:0] key_low;
    logic [39:0] key_high;
    logic [15:0] packet_length;
    logic [63:0] timestamp;
  } in_item_t;

  // result beat
  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic [63:0] packets_now;
    logic [63:0] bytes_now;
    logic [63:0] drop_total;
  } out_item_t;

  // lookup record travelling down the chain
  typedef struct packed {
    logic              valid;
    logic              hit;
    status_t           status;
    logic [KEY_W-1:0]  key;
    logic [15:0]       len;
    logic [63:0]       ts;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       packets;
    logic [63:0]       bytes;
  } probe_t;

endpackage

// ===== design/fst_cell.sv =====
// one table slot: key, counters and latest timestamp, plus one stage of the lookup chain
module fst_cell import fst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [SLOT_W-1:0] cell_index,
  input  probe_t            probe_in,
  output probe_t            probe_out,
  output logic              used
);

  logic [KEY_W-1:0] key;
  logic [63:0]      packets;
  logic [63:0]      bytes;
  // held as part of the entry, no result reads it back
  logic [63:0]      stamp;
  probe_t           probe;
  probe_t           probe_next;

  logic             match;
  logic             claim;
  logic [63:0]      packets_next;
  logic [63:0]      bytes_next;

  // match against this slot, or take it when it is the first free one
  always_comb begin
    match        = used && (key == probe_in.key);
    claim        = probe_in.valid && !probe_in.hit && (match || !used);
    packets_next = match ? packets + 64'd1 : 64'd1;
    bytes_next   = match ? bytes + {48'd0, probe_in.len} : {48'd0, probe_in.len};
    probe_next   = probe_in;
    if (claim) begin
      probe_next.hit     = 1'b1;
      probe_next.status  = match ? ST_UPDATED : ST_INSERTED;
      probe_next.slot    = cell_index;
      probe_next.packets = packets_next;
      probe_next.bytes   = bytes_next;
    end
  end

  // slot entry and hand-on of the record
  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= 1'b0;
      probe.valid <= 1'b0;
    end else if (advance) begin
      probe <= probe_next;
      if (claim) begin
        used    <= 1'b1;
        key     <= probe_in.key;
        packets <= packets_next;
        bytes   <= bytes_next;
        stamp   <= probe_in.ts;
      end
    end
  end

  assign probe_out = probe;

endmodule

// ===== design/fst_tail.sv =====
// end of the chain: drop counter, result register and chain advance
module fst_tail import fst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  probe_t    probe_in,
  input  logic      result_ready,
  output out_item_t result,
  output logic      result_valid,
  output logic      advance
);

  logic [63:0] drops;
  logic [63:0] drops_next;
  out_item_t   result_next;

  // the whole chain moves whenever the result register can take a beat
  assign advance = !result_valid || result_ready;

  // build the result beat
  always_comb begin
    drops_next = drops;
    if (probe_in.valid && !probe_in.hit) begin
      drops_next = drops + 64'd1;
    end
    if (probe_in.hit) begin
      result_next.status      = probe_in.status;
      result_next.slot        = 8'(probe_in.slot);
      result_next.packets_now = probe_in.packets;
      result_next.bytes_now   = probe_in.bytes;
    end else begin
      result_next.status      = ST_DROPPED;
      result_next.slot        = 8'd0;
      result_next.packets_now = 64'd0;
      result_next.bytes_now   = 64'd0;
    end
    result_next.drop_total = drops_next;
  end

  // result register and drop count
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      drops        <= 64'd0;
    end else if (advance) begin
      result_valid <= probe_in.valid;
      if (probe_in.valid) begin
        result <= result_next;
        drops  <= drops_next;
      end
    end
  end

endmodule

// ===== design/flow_statistics_table.sv =====
// flow statistics table top level: input stage, chain of slot cells and result stage
//
// Exact-match flow accounting. Each input beat (item) carries a flow key, a packet
// length and a timestamp; each beat gives exactly one result beat, in order.
// A hit updates the slot's packet and byte counts, a miss takes the next free slot,
// and a miss on a full table counts a drop.
// Both channels are valid/ready. The lookup record walks down a row of FLOW_SLOTS
// cells, one cell per cycle while the row is not stalled, so a beat trails the
// previous one by one cell and back-to-back beats of one flow see each other's
// updates in every cell. Throughput: one item per cycle while the row advances.
// Each record passes the FLOW_SLOTS cell registers and then the result register
// before result_valid rises.
// Reset empties the table (slot allocation flags cleared) and
// clears the drop count; item_ready is low during reset and high in the cycle
// after it.
// When the receiver holds result_ready low with a result waiting, the whole
// row stops and item_ready falls until the result beat is taken.
module flow_statistics_table import fst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  probe_t                chain [FLOW_SLOTS+1];
  probe_t                entry_probe;
  logic [FLOW_SLOTS-1:0] cell_used;
  logic                  advance;

  assign item_ready = advance && !rst;

  // record entering the first cell
  always_comb begin
    entry_probe        = '0;
    entry_probe.valid  = item_valid;
    entry_probe.hit    = 1'b0;
    entry_probe.status = ST_UPDATED;
    entry_probe.key    = KEY_W'({item.key_high, item.key_low});
    entry_probe.len    = item.packet_length;
    entry_probe.ts     = item.timestamp;
  end

  assign chain[0] = entry_probe;

  // row of slot cells
  for (genvar k = 0; k < FLOW_SLOTS; k++) begin : g_cell
    fst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (SLOT_W'(k)),
      .probe_in   (chain[k]),
      .probe_out  (chain[k+1]),
      .used       (cell_used[k])
    );
  end

  fst_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .probe_in     (chain[FLOW_SLOTS]),
    .result_ready (result_ready),
    .result       (result),
    .result_valid (result_valid),
    .advance      (advance)
  );

  // slots fill from the front: a taken slot never follows a free one
  a_used_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_used >> 1) & ~cell_used) == '0)
    else $error("slot allocation not contiguous");

  // a drop only ever comes from a full table
  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_DROPPED) |-> cell_used[FLOW_SLOTS-1])
    else $error("drop reported with a free slot");

  // the first slot, once taken, stays taken
  a_used_sticky: assert property (@(posedge clk) disable iff (rst)
    cell_used[0] |=> cell_used[0])
    else $error("first slot released");

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule
